FILE: hw/rtl/uvst_pkg.sv
// Shared constants, codes and transaction types for the unique value set table.
package uvst_pkg;

  // Table geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int FILL_W   = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [FILL_W-1:0]   fill_count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RD_LAST,
    S_MOVE
  } state_t;

  typedef enum logic [1:0] {
    POS_ZERO,
    POS_HIT,
    POS_SLOT,
    POS_COUNT
  } pos_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                scan;
    logic                rd_last;
    logic                hold_slot;
    logic                wr_append;
    logic                wr_move;
    logic                emit;
    logic [STATUS_W-1:0] status;
    pos_sel_t            pos_sel;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic            hit;
    logic            scan_end;
    logic            count_zero;
    logic            count_full;
    logic [OP_W-1:0] op;
  } dp_stat_t;

endpackage

FILE: hw/rtl/uvst_dp.sv
// Datapath: entry memory, fill count, scan pointer, compare and result register.
module uvst_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  uvst_pkg::in_item_t in_item,
  input  uvst_pkg::dp_cmd_t  cmd,
  output uvst_pkg::dp_stat_t stat,
  output logic               out_strobe,
  output uvst_pkg::out_item_t out_item
);
  import uvst_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;

  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] value_r;
  logic [CNT_W-1:0] idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] slot_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] last_cnt;
  logic             issue;
  logic             out_strobe_r;
  out_item_t        out_r;
  logic [IDX_W-1:0] pos_sel_val;

  // Address and write steering
  assign last_cnt = CNT_W'(count_r - 1'b1);
  assign issue    = cmd.scan && (idx_r < count_r);
  assign rd_addr  = cmd.rd_last ? last_cnt[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign wr_en    = cmd.wr_append | cmd.wr_move;
  assign wr_addr  = cmd.wr_append ? count_r[IDX_W-1:0] : slot_r;
  assign wr_data  = cmd.wr_append ? value_r : rd_data_r;

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // Latch the request, advance the scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.op;
      value_r <= in_item.value;
      idx_r   <= '0;
    end else if (issue) begin
      idx_r <= CNT_W'(idx_r + 1'b1);
    end
    if (issue) begin
      cmp_idx_r <= idx_r[IDX_W-1:0];
    end
    if (cmd.hold_slot) begin
      slot_r <= cmp_idx_r;
    end
  end

  // Track which compare slot holds fresh read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.load) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
    end
  end

  // Fill count
  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_append) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (cmd.wr_move) begin
      count_nxt = last_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result position select
  always_comb begin
    case (cmd.pos_sel)
      POS_ZERO:  pos_sel_val = '0;
      POS_HIT:   pos_sel_val = cmp_idx_r;
      POS_SLOT:  pos_sel_val = slot_r;
      POS_COUNT: pos_sel_val = count_r[IDX_W-1:0];
      default:   pos_sel_val = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status     <= cmd.status;
      out_r.position   <= POS_W'(pos_sel_val);
      out_r.fill_count <= FILL_W'(count_nxt);
    end
  end

  // Status back to the controller
  assign stat.hit        = cmp_vld_r && (rd_data_r == value_r);
  assign stat.scan_end   = !cmp_vld_r && (idx_r >= count_r);
  assign stat.count_zero = (count_r == '0);
  assign stat.count_full = (count_r >= CNT_W'(CAPACITY));
  assign stat.op         = op_r;

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

FILE: hw/rtl/uvst_ctrl.sv
// Controller: sequences scan, decision, last-entry move and result emission.
module uvst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  uvst_pkg::dp_stat_t stat,
  output uvst_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import uvst_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status  = ST_NOTFOUND;
    cmd.pos_sel = POS_ZERO;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          cmd.hold_slot = 1'b1;
          case (stat.op)
            OP_INSERT: begin
              cmd.emit   = 1'b1;
              cmd.status = ST_DUP;
              state_nxt  = S_IDLE;
            end
            OP_SEARCH: begin
              cmd.emit    = 1'b1;
              cmd.status  = ST_OK;
              cmd.pos_sel = POS_HIT;
              state_nxt   = S_IDLE;
            end
            OP_REMOVE: begin
              state_nxt = S_RD_LAST;
            end
            default: begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end else if (stat.scan_end) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
          case (stat.op)
            OP_INSERT: begin
              if (stat.count_full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.wr_append = 1'b1;
                cmd.status    = ST_OK;
                cmd.pos_sel   = POS_COUNT;
              end
            end
            OP_REMOVE: begin
              cmd.status = stat.count_zero ? ST_EMPTY : ST_NOTFOUND;
            end
            default: begin
              cmd.status = ST_NOTFOUND;
            end
          endcase
        end
      end
      S_RD_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        cmd.wr_move = 1'b1;
        cmd.emit    = 1'b1;
        cmd.status  = ST_OK;
        cmd.pos_sel = POS_SLOT;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: hw/rtl/unique_value_set_table_top.sv
// Top level of the unique value set table: controller plus datapath.
//
// A small unordered set of up to CAPACITY 32-bit values. Each transaction
// carries an op (insert if absent, search, remove) and a value word. A
// transaction is taken on a rising edge with start high and busy low; busy
// stays high until the result is decided. Exactly one result per
// transaction appears on out_item for one cycle, marked by out_strobe:
// status, position of the slot found or written, and the fill count after
// the operation. Remove fills the freed slot with the last entry.
// The scan reads one stored entry per cycle through the entry memory's
// single registered read port. A scan ends when a compare matches or all
// stored entries have been compared; a remove that finds its value then
// reads the last entry and moves it into the freed slot before its result.
// A new transaction can be taken in the cycle that out_strobe is high.
// Reset (synchronous, active low) empties the table and drops any
// transaction in flight. The receiver cannot stall: each result is
// taken in its strobe cycle.
module unique_value_set_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  uvst_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output uvst_pkg::out_item_t out_item
);
  import uvst_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  uvst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  uvst_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: hw/rtl/uvst_chk.sv
// Port-level checker for the unique value set table, bound to the top level.
module uvst_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input uvst_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input uvst_pkg::out_item_t out_item
);
  import uvst_pkg::*;

  // An accepted transaction keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // Results never come back to back
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  // Failed operations report position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status != ST_OK)) |-> (out_item.position == '0))
    else $error("nonzero position on failed operation");

  // Fill count never exceeds capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.fill_count <= FILL_W'(CAPACITY)))
    else $error("fill count above capacity");

  // A full report carries a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == ST_FULL))
      |-> (out_item.fill_count == FILL_W'(CAPACITY)))
    else $error("table full reported below capacity");

endmodule

bind unique_value_set_table_top uvst_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
